// ----- rtl/core/ppc_pkg.sv -----
// Package for the polygon point containment block.
// Holds the item codes, result status codes and the controller/datapath command and status types.
// No dependencies.
package ppc_pkg;

    localparam logic [1:0] OP_APPEND    = 2'd0;
    localparam logic [1:0] OP_QUERY     = 2'd1;
    localparam int         OP_CLEAR_BIT = 1;

    localparam int COUNT_OUT_BITS = 7;
    localparam int MIN_VERTICES   = 3;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_ANSWERED  = 3'd3,
        ST_TOO_FEW   = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef struct packed {
        logic load;
        logic walk_start;
        logic walk_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_needed;
        logic walk_last;
        logic pipe_empty;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/core/ppc_if.sv -----
// Valid/ready channel interfaces for the polygon point containment block.
// The item channel carries an operation and a point; the result channel carries the answer.
// No dependencies.
interface ppc_item_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, output op, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input op, input coord_x, input coord_y, output ready);
endinterface

interface ppc_result_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [2:0] status;
    logic [6:0] vertex_count;

    modport source (output valid, output inside_res, output status, output vertex_count,
                    input ready);
    modport sink   (input valid, input inside_res, input status, input vertex_count,
                    output ready);
endinterface

// ----- rtl/core/polygon_point_containment.sv -----
// Top level of the polygon point containment block (even-odd ray casting).
// Instantiates ppc_controller and ppc_datapath; uses ppc_pkg, ppc_item_if and ppc_result_if.
//
//   Channel   Direction  Payload                            Transaction
//   i_item    in         op, coord_x, coord_y               one append, query or clear
//   o_result  out        inside_res, status, vertex_count   one result per item
//
// Append, clear and queries answered without an edge walk pass through the execute and
// done states before the result register is written. A query that walks the polygon
// also passes through the walk and drain states, its pace set by the single read port
// of the vertex memory, which yields one vertex a cycle into an edge pipeline of read
// data, set-up, products and parity that is then drained.
// Reset clears the vertex count and bounding box; the vertex memory needs no clearing.
// A new item is taken while a finished result waits; a stalled result holds the next one.
module polygon_point_containment #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ppc_item_if.sink            i_item,
    ppc_result_if.source        o_result
);

    ppc_pkg::t_dp_cmd cmd;
    ppc_pkg::t_dp_sts sts;

    ppc_controller u_controller (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    ppc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_item.op),
        .i_coord_x      (i_item.coord_x),
        .i_coord_y      (i_item.coord_y),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_inside_res   (o_result.inside_res),
        .o_status       (o_result.status),
        .o_vertex_count (o_result.vertex_count)
    );

endmodule

// ----- rtl/core/ppc_controller.sv -----
// Sequencing state machine for the polygon point containment block.
// Issues commands to ppc_datapath and reacts to its status; uses ppc_pkg.
module ppc_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  ppc_pkg::t_dp_sts  i_sts,
    output ppc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.walk_needed) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/ppc_datapath.sv -----
// Datapath of the polygon point containment block: vertex memory, bounding box,
// edge-crossing pipeline and result register. Driven by ppc_controller; uses ppc_pkg.
module ppc_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppc_pkg::t_dp_cmd             i_cmd,
    output ppc_pkg::t_dp_sts             o_sts,
    input  logic [1:0]                   i_op,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_inside_res,
    output logic [2:0]                   o_status,
    output logic [ppc_pkg::COUNT_OUT_BITS-1:0] o_vertex_count
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [2*COORD_BITS-1:0] r_mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] r_rd_data;

    logic [1:0]                   r_op;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [CW-1:0]                r_count, n_count;
    logic signed [COORD_BITS-1:0] r_box_x_min, r_box_x_max, r_box_y_min, r_box_y_max;
    logic signed [COORD_BITS-1:0] n_box_x_min, n_box_x_max, n_box_y_min, n_box_y_max;
    logic signed [COORD_BITS-1:0] r_last_x, r_last_y;
    logic [CW-1:0]                r_rd_addr;

    logic                         r_s1_valid, r_s1_close, r_have_prev;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic                         r_s2_valid, r_s2_straddle;
    logic signed [DW-1:0]         r_a, r_b, r_c, r_d;
    logic                         r_s3_valid, r_s3_straddle;
    logic signed [PW-1:0]         r_ad, r_bc;
    logic                         r_parity;

    logic                         r_out_valid, r_out_inside;
    ppc_pkg::t_status             r_out_status, n_status;
    logic                         n_inside;

    logic is_clear, is_append, is_query, dup, full, few, in_box, do_write;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic signed [DW-1:0]         n_a, n_b, n_c, n_d;
    logic                         n_straddle;

    assign is_clear  = r_op[ppc_pkg::OP_CLEAR_BIT];
    assign is_append = (r_op == ppc_pkg::OP_APPEND);
    assign is_query  = (r_op == ppc_pkg::OP_QUERY);
    assign dup  = (r_count != '0) && (r_last_x == r_px) && (r_last_y == r_py);
    assign full = (r_count >= CW'(MAX_VERTICES));
    assign few  = (r_count < CW'(ppc_pkg::MIN_VERTICES));
    assign in_box = !((r_px < r_box_x_min) || (r_px > r_box_x_max) ||
                      (r_py < r_box_y_min) || (r_py > r_box_y_max));
    assign do_write = i_cmd.commit && is_append && !dup && !full;

    assign o_sts.walk_needed = is_query && !few && in_box;
    assign o_sts.walk_last   = (r_rd_addr == r_count);
    assign o_sts.pipe_empty  = !(r_s1_valid || r_s2_valid || r_s3_valid);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // Result and state update for the item being completed.
    always_comb begin
        n_count     = r_count;
        n_box_x_min = r_box_x_min;
        n_box_x_max = r_box_x_max;
        n_box_y_min = r_box_y_min;
        n_box_y_max = r_box_y_max;
        n_inside    = 1'b0;
        n_status    = ppc_pkg::ST_ANSWERED;
        if (is_clear) begin
            n_count     = '0;
            n_box_x_min = '0;
            n_box_x_max = '0;
            n_box_y_min = '0;
            n_box_y_max = '0;
            n_status    = ppc_pkg::ST_CLEARED;
        end else if (is_append) begin
            if (dup) begin
                n_status = ppc_pkg::ST_DUPLICATE;
            end else if (full) begin
                n_status = ppc_pkg::ST_FULL;
            end else begin
                n_status = ppc_pkg::ST_APPENDED;
                n_count  = r_count + CW'(1);
                if (r_count == '0) begin
                    n_box_x_min = r_px;
                    n_box_x_max = r_px;
                    n_box_y_min = r_py;
                    n_box_y_max = r_py;
                end else begin
                    if (r_px < r_box_x_min) n_box_x_min = r_px;
                    if (r_px > r_box_x_max) n_box_x_max = r_px;
                    if (r_py < r_box_y_min) n_box_y_min = r_py;
                    if (r_py > r_box_y_max) n_box_y_max = r_py;
                end
            end
        end else if (few) begin
            n_status = ppc_pkg::ST_TOO_FEW;
        end else begin
            n_status = ppc_pkg::ST_ANSWERED;
            n_inside = in_box && r_parity;
        end
    end

    // Edge set-up: the ray test px < x1 + (x2-x1)(py-y1)/(y2-y1) becomes
    // a*d < b*c once d has been made positive.
    always_comb begin
        cur_x = r_s1_close ? r_first_x : r_rd_data[COORD_BITS-1:0];
        cur_y = r_s1_close ? r_first_y : r_rd_data[2*COORD_BITS-1:COORD_BITS];
        n_straddle = (r_prev_y > r_py) != (cur_y > r_py);
        n_a = DW'(r_px) - DW'(r_prev_x);
        n_b = DW'(cur_x) - DW'(r_prev_x);
        n_c = DW'(r_py) - DW'(r_prev_y);
        n_d = DW'(cur_y) - DW'(r_prev_y);
        if (n_d < 0) begin
            n_d = -n_d;
            n_c = -n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_count[AW-1:0]] <= {r_py, r_px};
        end
        if (i_cmd.walk_step && (r_rd_addr != r_count)) begin
            r_rd_data <= r_mem[r_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (do_write) begin
            r_last_x <= r_px;
            r_last_y <= r_py;
        end
        if (r_s1_valid) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
            if (!r_have_prev) begin
                r_first_x <= cur_x;
                r_first_y <= cur_y;
            end
        end
        r_a           <= n_a;
        r_b           <= n_b;
        r_c           <= n_c;
        r_d           <= n_d;
        r_s2_straddle <= n_straddle;
        r_ad          <= r_a * r_d;
        r_bc          <= r_b * r_c;
        r_s3_straddle <= r_s2_straddle;
        if (i_cmd.commit) begin
            r_out_inside <= n_inside;
            r_out_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_box_x_min <= '0;
            r_box_x_max <= '0;
            r_box_y_min <= '0;
            r_box_y_max <= '0;
            r_rd_addr   <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_close  <= 1'b0;
            r_have_prev <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_box_x_min <= n_box_x_min;
                r_box_x_max <= n_box_x_max;
                r_box_y_min <= n_box_y_min;
                r_box_y_max <= n_box_y_max;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.walk_start) begin
                r_rd_addr   <= '0;
                r_have_prev <= 1'b0;
            end else if (r_s1_valid) begin
                r_have_prev <= 1'b1;
            end

            r_s1_valid <= 1'b0;
            if (i_cmd.walk_step) begin
                r_s1_valid <= 1'b1;
                r_s1_close <= (r_rd_addr == r_count);
                if (r_rd_addr != r_count) begin
                    r_rd_addr <= r_rd_addr + CW'(1);
                end
            end

            r_s2_valid <= r_s1_valid && r_have_prev;
            r_s3_valid <= r_s2_valid;

            if (i_cmd.walk_start) begin
                r_parity <= 1'b0;
            end else if (r_s3_valid && r_s3_straddle && (r_ad < r_bc)) begin
                r_parity <= !r_parity;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_inside_res   = r_out_inside;
    assign o_status       = r_out_status;
    assign o_vertex_count = ppc_pkg::COUNT_OUT_BITS'(r_count);

endmodule
